// ===== hdl/lcag_pkg.sv =====
// shared types and constants for the life cellular automaton grid
`default_nettype none

package lcag_pkg;

    // field widths of the stream transfers
    localparam int CMD_W      = 2;
    localparam int COORD_W    = 5;
    localparam int ROW_BITS_W = 32;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 32;

    // command codes carried on the input tuser
    typedef enum logic [CMD_W-1:0] {
        CMD_SET     = 2'd0,
        CMD_ADVANCE = 2'd1,
        CMD_READ    = 2'd2
    } cmd_t;

endpackage

`default_nettype wire

// ===== hdl/lcag_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
`default_nettype none

module lcag_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [DATA_W-1:0]        wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/lcag_rule.sv =====
// b3/s23 life rule applied to one row from a three-row window
`default_nettype none

module lcag_rule #(
    parameter int GRID_SIZE = 32
) (
    input  wire logic [GRID_SIZE-1:0] above,
    input  wire logic [GRID_SIZE-1:0] mid,
    input  wire logic [GRID_SIZE-1:0] below,
    output logic      [GRID_SIZE-1:0] next_row
);

    logic [GRID_SIZE+1:0] up_pad;
    logic [GRID_SIZE+1:0] mid_pad;
    logic [GRID_SIZE+1:0] dn_pad;

    // dead cells beyond the left and right borders
    assign up_pad  = {1'b0, above, 1'b0};
    assign mid_pad = {1'b0, mid, 1'b0};
    assign dn_pad  = {1'b0, below, 1'b0};

    // per column: count the eight neighbours, then birth or survival
    for (genvar c = 0; c < GRID_SIZE; c++) begin : g_col
        logic [3:0] nbr_cnt;
        assign nbr_cnt = 4'(up_pad[c]) + 4'(up_pad[c+1]) + 4'(up_pad[c+2])
                       + 4'(mid_pad[c]) + 4'(mid_pad[c+2])
                       + 4'(dn_pad[c]) + 4'(dn_pad[c+1]) + 4'(dn_pad[c+2]);
        assign next_row[c] = (nbr_cnt == 4'd3) || (mid[c] && (nbr_cnt == 4'd2));
    end

endmodule

`default_nettype wire

// ===== hdl/life_cellular_automaton_grid.sv =====
// life grid: command decode, row memory and generation sweep
// set and read first read the addressed row, advance sweeps every row, and a rejected or
// unknown command goes straight to the response state, which feeds the output register
// throughput: one command at a time, no input transfer until the result has been handed
// to the output register, later while it still holds an unaccepted result; advance sweeps
// one row read and one row written per cycle through a three-row window
// reset (aresetn low, synchronous) clears the row valid bits: all cells dead.
`default_nettype none

module life_cellular_automaton_grid #(
    parameter int GRID_SIZE = 32
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // input channel
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [lcag_pkg::S_TDATA_W-1:0] s_axis_tdata,  // row[4:0], col[9:5], alive[10]
    input  wire logic [lcag_pkg::CMD_W-1:0]     s_axis_tuser,  // cmd[1:0]
    // result channel
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    output logic      [lcag_pkg::M_TDATA_W-1:0] m_axis_tdata,  // row_bits[31:0]
    output logic                                m_axis_tuser   // ack[0]
);

    import lcag_pkg::*;

    localparam int AW = $clog2(GRID_SIZE);
    localparam int CW = $clog2(GRID_SIZE + 2);
    localparam logic [CW-1:0] CNT_ROWS = CW'(GRID_SIZE);
    localparam logic [CW-1:0] CNT_LAST = CW'(GRID_SIZE + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SET,
        ST_READ,
        ST_ADV,
        ST_RESP
    } state_t;

    state_t                 state_reg, state_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic [AW-1:0]          row_addr_reg, row_addr_next;
    logic [GRID_SIZE-1:0]   col_mask_reg, col_mask_next;
    logic                   alive_reg, alive_next;
    logic [GRID_SIZE-1:0]   prev_reg, prev_next;
    logic [GRID_SIZE-1:0]   cur_reg, cur_next;
    logic [ROW_BITS_W-1:0]  resp_bits_reg, resp_bits_next;
    logic                   resp_ack_reg, resp_ack_next;
    logic                   m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0]   m_data_reg, m_data_next;
    logic                   m_user_reg, m_user_next;
    logic [GRID_SIZE-1:0]   row_valid_reg;
    logic                   rd_vld_reg;

    logic                   rd_en;
    logic [AW-1:0]          rd_addr;
    logic [GRID_SIZE-1:0]   rd_data;
    logic [GRID_SIZE-1:0]   rd_eff;
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [GRID_SIZE-1:0]   wr_data;
    logic [GRID_SIZE-1:0]   below_row;
    logic [GRID_SIZE-1:0]   rule_row;
    logic [CW-1:0]          wr_cnt;

    logic [COORD_W-1:0]     in_row;
    logic [COORD_W-1:0]     in_col;
    logic                   in_alive;
    logic                   row_ok;
    logic                   col_ok;
    logic                   in_xfer;

    // input field unpacking
    assign in_row   = s_axis_tdata[COORD_W-1:0];
    assign in_col   = s_axis_tdata[2*COORD_W-1:COORD_W];
    assign in_alive = s_axis_tdata[2*COORD_W];
    assign row_ok   = 32'(in_row) < 32'(GRID_SIZE);
    assign col_ok   = 32'(in_col) < 32'(GRID_SIZE);

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    // row memory
    lcag_ram #(
        .DATA_W (GRID_SIZE),
        .DEPTH  (GRID_SIZE)
    ) u_rows (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // a row never written since reset reads as all dead
    assign rd_eff = rd_vld_reg ? rd_data : '0;

    // below the last row lies dead space
    assign below_row = (cnt_reg == CNT_LAST) ? '0 : rd_eff;
    assign wr_cnt    = cnt_reg - CW'(2);

    lcag_rule #(
        .GRID_SIZE (GRID_SIZE)
    ) u_rule (
        .above    (prev_reg),
        .mid      (cur_reg),
        .below    (below_row),
        .next_row (rule_row)
    );

    // command sequencing and memory port control
    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        row_addr_next  = row_addr_reg;
        col_mask_next  = col_mask_reg;
        alive_next     = alive_reg;
        prev_next      = prev_reg;
        cur_next       = cur_reg;
        resp_bits_next = resp_bits_reg;
        resp_ack_next  = resp_ack_reg;
        m_valid_next   = m_valid_reg && !m_axis_tready;
        m_data_next    = m_data_reg;
        m_user_next    = m_user_reg;
        rd_en          = 1'b0;
        rd_addr        = cnt_reg[AW-1:0];
        wr_en          = 1'b0;
        wr_addr        = row_addr_reg;
        wr_data        = alive_reg ? (rd_eff | col_mask_reg) : (rd_eff & ~col_mask_reg);

        unique case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    row_addr_next  = AW'(in_row);
                    col_mask_next  = GRID_SIZE'(1) << in_col;
                    alive_next     = in_alive;
                    resp_bits_next = '0;
                    resp_ack_next  = 1'b0;
                    unique case (s_axis_tuser)
                        CMD_SET: begin
                            if (row_ok && col_ok) begin
                                rd_en      = 1'b1;
                                rd_addr    = AW'(in_row);
                                state_next = ST_SET;
                            end else begin
                                state_next = ST_RESP;
                            end
                        end
                        CMD_READ: begin
                            if (row_ok) begin
                                rd_en      = 1'b1;
                                rd_addr    = AW'(in_row);
                                state_next = ST_READ;
                            end else begin
                                state_next = ST_RESP;
                            end
                        end
                        CMD_ADVANCE: begin
                            rd_en      = 1'b1;
                            rd_addr    = '0;
                            cnt_next   = CW'(1);
                            prev_next  = '0;
                            cur_next   = '0;
                            state_next = ST_ADV;
                        end
                        default: begin
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end
            ST_SET: begin
                // read-modify-write of the addressed row
                wr_en         = 1'b1;
                resp_ack_next = 1'b1;
                state_next    = ST_RESP;
            end
            ST_READ: begin
                resp_bits_next = ROW_BITS_W'(rd_eff);
                resp_ack_next  = 1'b1;
                state_next     = ST_RESP;
            end
            ST_ADV: begin
                // fetch one row ahead, write back the row two behind
                if (cnt_reg < CNT_ROWS) begin
                    rd_en = 1'b1;
                end
                prev_next = cur_reg;
                cur_next  = below_row;
                if (cnt_reg >= CW'(2)) begin
                    wr_en   = 1'b1;
                    wr_addr = wr_cnt[AW-1:0];
                    wr_data = rule_row;
                end
                if (cnt_reg == CNT_LAST) begin
                    resp_ack_next = 1'b1;
                    state_next    = ST_RESP;
                end else begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            ST_RESP: begin
                // hand the result to the output register once it is free
                if (!m_valid_reg || m_axis_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = resp_bits_reg;
                    m_user_next  = resp_ack_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state, window and output registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            m_valid_reg   <= 1'b0;
            row_valid_reg <= '0;
            rd_vld_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
            if (rd_en) begin
                rd_vld_reg <= row_valid_reg[rd_addr];
            end
            if (wr_en) begin
                row_valid_reg[wr_addr] <= 1'b1;
            end
        end
        row_addr_reg  <= row_addr_next;
        col_mask_reg  <= col_mask_next;
        alive_reg     <= alive_next;
        prev_reg      <= prev_next;
        cur_reg       <= cur_next;
        resp_bits_reg <= resp_bits_next;
        resp_ack_reg  <= resp_ack_next;
        m_data_reg    <= m_data_next;
        m_user_reg    <= m_user_next;
    end

    // one command in flight: an accepted transfer closes the input side
    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while a command is in flight");

    // the sweep never reads and writes the same row in one cycle
    a_no_collide: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_en && rd_en) |-> (wr_addr != rd_addr))
        else $error("row read and write collide");

    // results only leave from the response state
    a_resp_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_axis_tvalid) |-> ($past(state_reg) == ST_RESP))
        else $error("result posted outside the response state");

endmodule

`default_nettype wire
